### rtl/core/sha256_pkg.sv
// sha-256 package: round constants, initial hash, sequencer states and helpers
`default_nettype none
package sha256_pkg;

  localparam int unsigned BlockBytes = 64;
  localparam int unsigned Rounds     = 64;
  localparam int unsigned CountW     = 61;

  typedef enum logic [2:0] {
    StIdle,
    StRound,
    StFold,
    StPadFill,
    StEmit
  } state_e;

  typedef logic [31:0] word_t;

  function automatic word_t round_k(input logic [5:0] t);
    word_t k;
    case (t)
      6'd0: k = 32'h428a2f98;  6'd1: k = 32'h71374491;  6'd2: k = 32'hb5c0fbcf;
      6'd3: k = 32'he9b5dba5;  6'd4: k = 32'h3956c25b;  6'd5: k = 32'h59f111f1;
      6'd6: k = 32'h923f82a4;  6'd7: k = 32'hab1c5ed5;  6'd8: k = 32'hd807aa98;
      6'd9: k = 32'h12835b01;  6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
      6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe; 6'd14: k = 32'h9bdc06a7;
      6'd15: k = 32'hc19bf174; 6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
      6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc; 6'd20: k = 32'h2de92c6f;
      6'd21: k = 32'h4a7484aa; 6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
      6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d; 6'd26: k = 32'hb00327c8;
      6'd27: k = 32'hbf597fc7; 6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
      6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967; 6'd32: k = 32'h27b70a85;
      6'd33: k = 32'h2e1b2138; 6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
      6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb; 6'd38: k = 32'h81c2c92e;
      6'd39: k = 32'h92722c85; 6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
      6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3; 6'd44: k = 32'hd192e819;
      6'd45: k = 32'hd6990624; 6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
      6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08; 6'd50: k = 32'h2748774c;
      6'd51: k = 32'h34b0bcb5; 6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
      6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3; 6'd56: k = 32'h748f82ee;
      6'd57: k = 32'h78a5636f; 6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
      6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb; 6'd62: k = 32'hbef9a3f7;
      default: k = 32'hc67178f2;
    endcase
    return k;
  endfunction

  function automatic word_t init_hash(input logic [2:0] i);
    word_t h;
    case (i)
      3'd0: h = 32'h6a09e667; 3'd1: h = 32'hbb67ae85;
      3'd2: h = 32'h3c6ef372; 3'd3: h = 32'ha54ff53a;
      3'd4: h = 32'h510e527f; 3'd5: h = 32'h9b05688c;
      3'd6: h = 32'h1f83d9ab; default: h = 32'h5be0cd19;
    endcase
    return h;
  endfunction

  function automatic word_t rotr(input word_t x, input int unsigned n);
    return (x >> n) | (x << (32 - n));
  endfunction

endpackage
`default_nettype wire

### rtl/core/sha256_round.sv
// sha-256 round unit: one compression round on a given schedule word
`default_nettype none
module sha256_round (
  input  var sha256_pkg::word_t       vars_i [8],
  input  var sha256_pkg::word_t       w_i,
  input  var logic [5:0]              t_i,
  output var sha256_pkg::word_t       vars_o [8]
);
  sha256_pkg::word_t s1, ch, t1, s0, maj;
  always_comb begin
    s1 = sha256_pkg::rotr(vars_i[4], 6) ^ sha256_pkg::rotr(vars_i[4], 11)
       ^ sha256_pkg::rotr(vars_i[4], 25);
    ch = (vars_i[4] & vars_i[5]) ^ (~vars_i[4] & vars_i[6]);
    t1 = vars_i[7] + s1 + ch + sha256_pkg::round_k(t_i) + w_i;
    s0 = sha256_pkg::rotr(vars_i[0], 2) ^ sha256_pkg::rotr(vars_i[0], 13)
       ^ sha256_pkg::rotr(vars_i[0], 22);
    maj = (vars_i[0] & vars_i[1]) ^ (vars_i[0] & vars_i[2]) ^ (vars_i[1] & vars_i[2]);
    vars_o[7] = vars_i[6];
    vars_o[6] = vars_i[5];
    vars_o[5] = vars_i[4];
    vars_o[4] = vars_i[3] + t1;
    vars_o[3] = vars_i[2];
    vars_o[2] = vars_i[1];
    vars_o[1] = vars_i[0];
    vars_o[0] = t1 + s0 + maj;
  end
endmodule
`default_nettype wire

### rtl/core/sha256_stream_hasher.sv
// sha-256 streaming hasher top level
//
//  channel | dir | signals                                       | accepted when
//  input   | in  | message_byte_i has_byte_i end_of_message_i    | in_valid_i & !in_stall_o
//  output  | out | digest_word_o word_index_o last_word_o        | out_valid_o & !out_stall_i
//
// a byte item that does not fill the block is written into the schedule words and the hasher stays idle
// a full block is compressed in 64 rounds on the single round unit, then folded into the hash
// an end item pads the rest of the block one byte a cycle, then each padded block is compressed
// one or two padded blocks are compressed before the eight output items
// reset loads the initial hash and clears the byte count; the block words are not cleared
// out_stall_i holds the current digest word; no input item is taken until all eight are out
`default_nettype none
module sha256_stream_hasher (
  input  var logic        clk_i,
  input  var logic        rst_ni,
  input  var logic        in_valid_i,
  output var logic        in_stall_o,
  input  var logic [7:0]  message_byte_i,
  input  var logic        has_byte_i,
  input  var logic        end_of_message_i,
  output var logic        out_valid_o,
  input  var logic        out_stall_i,
  output var logic [31:0] digest_word_o,
  output var logic [2:0]  word_index_o,
  output var logic        last_word_o
);
  sha256_pkg::state_e state_q, state_d;
  sha256_pkg::word_t hash_q [8];
  sha256_pkg::word_t vars_q [8];
  sha256_pkg::word_t vars_n [8];
  sha256_pkg::word_t sched_q [16];
  logic [sha256_pkg::CountW-1:0] count_q;
  logic [5:0] t_q;
  logic [5:0] fill_q;
  logic [2:0] widx_q;
  logic fin_q, second_q, len_q;
  sha256_pkg::word_t w, a15, a2, g0, g1;
  logic [63:0] bits;
  logic acc;
  logic pad_here, len_ok, pad_done_q;
  logic [7:0] pad_byte;

  assign in_stall_o = (state_q != sha256_pkg::StIdle);
  assign acc = in_valid_i && !in_stall_o;
  assign bits = {count_q, 3'b000};

  // block bytes are packed big-endian into the schedule words
  always_comb begin
    a15 = sched_q[4'(t_q - 6'd15)];
    a2  = sched_q[4'(t_q - 6'd2)];
    g0 = sha256_pkg::rotr(a15, 7) ^ sha256_pkg::rotr(a15, 18) ^ (a15 >> 3);
    g1 = sha256_pkg::rotr(a2, 17) ^ sha256_pkg::rotr(a2, 19) ^ (a2 >> 10);
    if (t_q < 6'd16) begin
      w = sched_q[t_q[3:0]];
    end else begin
      w = sched_q[t_q[3:0]] + g0 + sched_q[4'(t_q - 6'd7)] + g1;
    end
  end

  sha256_round u_round (
    .vars_i (vars_q),
    .w_i    (w),
    .t_i    (t_q),
    .vars_o (vars_n)
  );

  always_comb begin
    state_d = state_q;
    case (state_q)
      sha256_pkg::StIdle: begin
        if (acc) begin
          if (has_byte_i && count_q[5:0] == 6'd63) state_d = sha256_pkg::StRound;
          else if (end_of_message_i) state_d = sha256_pkg::StPadFill;
        end
      end
      sha256_pkg::StRound: if (t_q == 6'd63) state_d = sha256_pkg::StFold;
      sha256_pkg::StFold: begin
        if (!fin_q) state_d = sha256_pkg::StIdle;
        else if (second_q) state_d = sha256_pkg::StEmit;
        else state_d = sha256_pkg::StPadFill;
      end
      sha256_pkg::StPadFill: if (fill_q == 6'd63) state_d = sha256_pkg::StRound;
      sha256_pkg::StEmit: begin
        if (!out_stall_i && widx_q == 3'd7) state_d = sha256_pkg::StIdle;
      end
      default: state_d = sha256_pkg::StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= sha256_pkg::StIdle;
      count_q <= '0;
      t_q <= '0;
      fill_q <= '0;
      widx_q <= '0;
      fin_q <= 1'b0;
      second_q <= 1'b0;
      len_q <= 1'b0;
      for (int i = 0; i < 8; i++) hash_q[i] <= sha256_pkg::init_hash(3'(i));
    end else begin
      state_q <= state_d;
      case (state_q)
        sha256_pkg::StIdle: begin
          if (acc) begin
            fin_q <= end_of_message_i;
            second_q <= 1'b0;
            len_q <= 1'b0;
            t_q <= '0;
            if (has_byte_i) begin
              count_q <= count_q + 1'b1;
              fill_q <= count_q[5:0] + 6'd1;
            end else begin
              fill_q <= count_q[5:0];
            end
          end
        end
        sha256_pkg::StRound: t_q <= t_q + 6'd1;
        sha256_pkg::StFold: begin
          for (int i = 0; i < 8; i++) hash_q[i] <= hash_q[i] + vars_q[i];
          fill_q <= '0;
          widx_q <= '0;
          len_q <= pad_done_q;
        end
        sha256_pkg::StPadFill: begin
          fill_q <= fill_q + 6'd1;
          t_q <= '0;
          if (fill_q == 6'd63 && len_ok) second_q <= 1'b1;
        end
        sha256_pkg::StEmit: begin
          if (!out_stall_i) begin
            widx_q <= widx_q + 3'd1;
            if (widx_q == 3'd7) begin
              for (int i = 0; i < 8; i++) hash_q[i] <= sha256_pkg::init_hash(3'(i));
              count_q <= '0;
            end
          end
        end
        default: ;
      endcase
    end
  end

  // length goes into this pass unless the pad spills into a second block
  always_comb begin
    pad_here = (fill_q == count_q[5:0]) && !pad_done_q;
    len_ok = (count_q[5:0] < 6'd56) || len_q;
    if (pad_here) pad_byte = 8'h80;
    else if (fill_q >= 6'd56 && len_ok)
      pad_byte = bits[8*(6'd63 - fill_q) +: 8];
    else pad_byte = 8'h00;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) pad_done_q <= 1'b0;
    else if (acc) pad_done_q <= 1'b0;
    else if (state_q == sha256_pkg::StPadFill && pad_here) pad_done_q <= 1'b1;
  end

  always_ff @(posedge clk_i) begin
    if (acc && has_byte_i)
      sched_q[count_q[5:2]][{~count_q[1:0], 3'b000} +: 8] <= message_byte_i;
    if (state_q == sha256_pkg::StPadFill)
      sched_q[fill_q[5:2]][{~fill_q[1:0], 3'b000} +: 8] <= pad_byte;
    if (state_q == sha256_pkg::StRound) begin
      sched_q[t_q[3:0]] <= w;
      vars_q <= vars_n;
    end
    if (state_q == sha256_pkg::StPadFill && fill_q == 6'd63) vars_q <= hash_q;
    if (state_q == sha256_pkg::StIdle && acc) vars_q <= hash_q;
  end

  assign out_valid_o = (state_q == sha256_pkg::StEmit);
  assign digest_word_o = hash_q[widx_q];
  assign word_index_o = widx_q;
  assign last_word_o = (widx_q == 3'd7);
endmodule
`default_nettype wire

### rtl/core/sha256_stream_hasher_chk.sv
// port-level checker for the sha-256 hasher, bound to the top level
`default_nettype none
module sha256_stream_hasher_chk (
  input var logic       clk_i,
  input var logic       rst_ni,
  input var logic       in_stall_o,
  input var logic       out_valid_o,
  input var logic       out_stall_i,
  input var logic [2:0] word_index_o,
  input var logic       last_word_o
);
  a_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (last_word_o == (word_index_o == 3'd7)))
    else $error("last_word mismatch");
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_stall_o)
    else $error("input taken while emitting");
  a_next: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_stall_i && !last_word_o) |=>
      (out_valid_o && word_index_o == $past(word_index_o) + 3'd1))
    else $error("digest word skipped");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(word_index_o)))
    else $error("stalled item changed");
endmodule

bind sha256_stream_hasher sha256_stream_hasher_chk u_chk (.*);
`default_nettype wire
